// ===== rtl/ipc_pkg.sv =====
// Shared types and constants for the inverse Park / inverse Clarke transform.
package ipc_pkg;

  localparam int ANGLE_BITS_DEF       = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  localparam int FIELD_W = 16;
  localparam int OUT_W   = 18;

  localparam longint unsigned PI_HALF_Q30    = 64'd1686629713;
  localparam longint unsigned SQRT3_HALF_Q30 = 64'd929887697;
  localparam longint unsigned TAYLOR_DIV [1:9] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  localparam logic [2:0] PM_90_3PH  = 3'd0;
  localparam logic [2:0] PM_120_3PH = 3'd1;
  localparam logic [2:0] PM_180_2PH = 3'd2;
  localparam logic [2:0] PM_180_3PH = 3'd3;
  localparam logic [2:0] PM_OFF     = 3'd4;

  localparam logic [1:0] REG_PHASE_MODE     = 2'd0;
  localparam logic [1:0] REG_POLE_COUNT     = 2'd1;
  localparam logic [1:0] REG_USE_EXT_SINCOS = 2'd2;

  typedef struct packed {
    logic [2:0] phase_mode;
    logic [7:0] pole_count;
    logic       use_ext_sincos;
  } cfg_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } pair_en_t;

endpackage

// ===== rtl/ipc_angle.sv =====
// Electrical angle and quarter-wave table index, two pipeline stages.
module ipc_angle #(
  parameter int ANGLE_BITS       = ipc_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ipc_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int IDX_W           = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                            clk,
  input  ipc_pkg::pair_en_t               en,
  input  logic [7:0]                      pole_count,
  input  logic [ipc_pkg::FIELD_W-1:0]     rotor_angle,
  input  logic signed [ipc_pkg::FIELD_W-1:0] d_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] q_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] ext_sine,
  input  logic signed [ipc_pkg::FIELD_W-1:0] ext_cosine,
  output logic [1:0]                      quad,
  output logic [IDX_W-1:0]                idx,
  output logic signed [ipc_pkg::FIELD_W-1:0] d_out,
  output logic signed [ipc_pkg::FIELD_W-1:0] q_out,
  output logic signed [ipc_pkg::FIELD_W-1:0] es_out,
  output logic signed [ipc_pkg::FIELD_W-1:0] ec_out
);

  localparam int LOW_W  = ANGLE_BITS - 2;
  localparam int PROD_W = LOW_W + IDX_W;

  logic [7:0]                          pole_eff;
  logic [ipc_pkg::FIELD_W+7:0]         ang_prod;
  logic [ANGLE_BITS-1:0]               ang_r;
  logic [ANGLE_BITS-1:0]               ang_nxt;
  logic [PROD_W-1:0]                   scaled;
  logic signed [ipc_pkg::FIELD_W-1:0]  d1_r, q1_r, es1_r, ec1_r;
  logic [1:0]                          quad_r;
  logic [IDX_W-1:0]                    idx_r;
  logic signed [ipc_pkg::FIELD_W-1:0]  d2_r, q2_r, es2_r, ec2_r;

  always_comb begin
    pole_eff = (pole_count == 8'd0) ? 8'd1 : pole_count;
    ang_prod = {8'd0, rotor_angle} * {{ipc_pkg::FIELD_W{1'b0}}, pole_eff};
    ang_nxt  = ang_prod[ANGLE_BITS-1:0];
    scaled   = {{IDX_W{1'b0}}, ang_r[LOW_W-1:0]} * PROD_W'(SINE_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      ang_r <= ang_nxt;
      d1_r  <= d_axis;
      q1_r  <= q_axis;
      es1_r <= ext_sine;
      ec1_r <= ext_cosine;
    end
    if (en.en_b) begin
      quad_r <= ang_r[ANGLE_BITS-1:ANGLE_BITS-2];
      idx_r  <= scaled[LOW_W +: IDX_W];
      d2_r   <= d1_r;
      q2_r   <= q1_r;
      es2_r  <= es1_r;
      ec2_r  <= ec1_r;
    end
  end

  assign quad   = quad_r;
  assign idx    = idx_r;
  assign d_out  = d2_r;
  assign q_out  = q2_r;
  assign es_out = es2_r;
  assign ec_out = ec2_r;

endmodule

// ===== rtl/ipc_sincos.sv =====
// Quarter-wave sine table lookup and quadrant folding, two pipeline stages.
module ipc_sincos #(
  parameter int SINE_TABLE_DEPTH = ipc_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int IDX_W           = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                               clk,
  input  ipc_pkg::pair_en_t                  en,
  input  logic                               use_ext_sincos,
  input  logic [1:0]                         quad,
  input  logic [IDX_W-1:0]                   idx,
  input  logic signed [ipc_pkg::FIELD_W-1:0] d_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] q_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] ext_sine,
  input  logic signed [ipc_pkg::FIELD_W-1:0] ext_cosine,
  output logic signed [ipc_pkg::FIELD_W-1:0] sine,
  output logic signed [ipc_pkg::FIELD_W-1:0] cosine,
  output logic signed [ipc_pkg::FIELD_W-1:0] d_out,
  output logic signed [ipc_pkg::FIELD_W-1:0] q_out
);

  typedef logic [14:0] tab_t [SINE_TABLE_DEPTH+1];

  function automatic tab_t build_tab();
    tab_t            t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          s;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = ipc_pkg::PI_HALF_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / ipc_pkg::TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      s = longint'((longint'(unsigned'(sum)) * 64'd32767 + (64'd1 << 29)) >> 30);
      if (s > 32767) begin
        s = 32767;
      end
      t[k] = s[14:0];
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [14:0]                        lo_r, hi_r;
  logic [1:0]                         quad_r;
  logic signed [ipc_pkg::FIELD_W-1:0] d3_r, q3_r, es3_r, ec3_r;
  logic signed [ipc_pkg::FIELD_W-1:0] lo_s, hi_s;
  logic signed [ipc_pkg::FIELD_W-1:0] sin_nxt, cos_nxt;
  logic signed [ipc_pkg::FIELD_W-1:0] sin_r, cos_r, d4_r, q4_r;

  always_comb begin
    lo_s = $signed({1'b0, lo_r});
    hi_s = $signed({1'b0, hi_r});
    case (quad_r)
      2'd0: begin
        sin_nxt = lo_s;
        cos_nxt = hi_s;
      end
      2'd1: begin
        sin_nxt = hi_s;
        cos_nxt = -lo_s;
      end
      2'd2: begin
        sin_nxt = -lo_s;
        cos_nxt = -hi_s;
      end
      default: begin
        sin_nxt = -hi_s;
        cos_nxt = lo_s;
      end
    endcase
    if (use_ext_sincos) begin
      sin_nxt = es3_r;
      cos_nxt = ec3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      lo_r   <= SINE_TAB[idx];
      hi_r   <= SINE_TAB[IDX_W'(SINE_TABLE_DEPTH) - idx];
      quad_r <= quad;
      d3_r   <= d_axis;
      q3_r   <= q_axis;
      es3_r  <= ext_sine;
      ec3_r  <= ext_cosine;
    end
    if (en.en_b) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
      d4_r  <= d3_r;
      q4_r  <= q3_r;
    end
  end

  assign sine   = sin_r;
  assign cosine = cos_r;
  assign d_out  = d4_r;
  assign q_out  = q4_r;

endmodule

// ===== rtl/ipc_rotate.sv =====
// Inverse Park rotation: products, then rounded sums, two pipeline stages.
module ipc_rotate (
  input  logic                               clk,
  input  ipc_pkg::pair_en_t                  en,
  input  logic signed [ipc_pkg::FIELD_W-1:0] d_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] q_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] sine,
  input  logic signed [ipc_pkg::FIELD_W-1:0] cosine,
  output logic signed [ipc_pkg::OUT_W-1:0]   alpha,
  output logic signed [ipc_pkg::OUT_W-1:0]   beta
);

  logic signed [31:0] dc_r, qs_r, ds_r, qc_r;
  logic signed [32:0] sum_a, sum_b;
  logic signed [ipc_pkg::OUT_W-1:0] alpha_r, beta_r;

  always_comb begin
    sum_a = {dc_r[31], dc_r} - {qs_r[31], qs_r} + 33'sd16384;
    sum_b = {ds_r[31], ds_r} + {qc_r[31], qc_r} + 33'sd16384;
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      dc_r <= d_axis * cosine;
      qs_r <= q_axis * sine;
      ds_r <= d_axis * sine;
      qc_r <= q_axis * cosine;
    end
    if (en.en_b) begin
      alpha_r <= sum_a[32:15];
      beta_r  <= sum_b[32:15];
    end
  end

  assign alpha = alpha_r;
  assign beta  = beta_r;

endmodule

// ===== rtl/ipc_phase.sv =====
// Phase mapping from alpha and beta onto U, V and W, two pipeline stages.
module ipc_phase (
  input  logic                             clk,
  input  ipc_pkg::pair_en_t                en,
  input  logic [2:0]                       phase_mode,
  input  logic signed [ipc_pkg::OUT_W-1:0] alpha,
  input  logic signed [ipc_pkg::OUT_W-1:0] beta,
  output logic signed [ipc_pkg::OUT_W-1:0] alpha_out,
  output logic signed [ipc_pkg::OUT_W-1:0] beta_out,
  output logic signed [ipc_pkg::OUT_W-1:0] phase_u,
  output logic signed [ipc_pkg::OUT_W-1:0] phase_v,
  output logic signed [ipc_pkg::OUT_W-1:0] phase_w
);

  localparam logic signed [30:0] SQRT3_HALF = 31'(ipc_pkg::SQRT3_HALF_Q30);

  logic signed [ipc_pkg::OUT_W-1:0] alpha7_r, beta7_r;
  logic signed [48:0]               m_r;
  logic signed [49:0]               a_sh, v_sum, w_sum;
  logic signed [ipc_pkg::OUT_W:0]   half;
  logic signed [ipc_pkg::OUT_W-1:0] u_nxt, v_nxt, w_nxt;
  logic signed [ipc_pkg::OUT_W-1:0] alpha_r, beta_r, u_r, v_r, w_r;

  always_comb begin
    a_sh  = 50'(alpha7_r) <<< 29;
    v_sum = -a_sh + 50'(m_r) + (50'sd1 <<< 29);
    w_sum = -a_sh - 50'(m_r) + (50'sd1 <<< 29);
    half  = (19'(beta7_r) + 19'sd1) >>> 1;
    case (phase_mode)
      ipc_pkg::PM_90_3PH: begin
        u_nxt = alpha7_r;
        v_nxt = '0;
        w_nxt = beta7_r;
      end
      ipc_pkg::PM_120_3PH: begin
        u_nxt = alpha7_r;
        v_nxt = v_sum[47:30];
        w_nxt = w_sum[47:30];
      end
      ipc_pkg::PM_180_2PH: begin
        u_nxt = half[ipc_pkg::OUT_W-1:0];
        v_nxt = '0;
        w_nxt = -half[ipc_pkg::OUT_W-1:0];
      end
      ipc_pkg::PM_180_3PH: begin
        u_nxt = half[ipc_pkg::OUT_W-1:0];
        v_nxt = alpha7_r;
        w_nxt = -half[ipc_pkg::OUT_W-1:0];
      end
      default: begin
        u_nxt = '0;
        v_nxt = '0;
        w_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.en_a) begin
      alpha7_r <= alpha;
      beta7_r  <= beta;
      m_r      <= beta * SQRT3_HALF;
    end
    if (en.en_b) begin
      alpha_r <= alpha7_r;
      beta_r  <= beta7_r;
      u_r     <= u_nxt;
      v_r     <= v_nxt;
      w_r     <= w_nxt;
    end
  end

  assign alpha_out = alpha_r;
  assign beta_out  = beta_r;
  assign phase_u   = u_r;
  assign phase_v   = v_r;
  assign phase_w   = w_r;

endmodule

// ===== rtl/inverse_park_clarke_transform_top.sv =====
// Top level of the inverse Park / inverse Clarke transform pipeline.
//
// Input channel (in_valid/in_ready): d and q axis values, mechanical rotor
// angle and an external sine/cosine pair, one transaction per item.
// Result channel (out_valid/out_ready): alpha, beta and phase U, V, W.
// Configuration: APB-style port, phase_mode at 0x0, pole_count at 0x4,
// use_ext_sincos at 0x8; pready is always high, reads return the register.
// Pipeline: each result passes through the eight register stages in order
// (angle multiply, index scale, table read, quadrant fold, rotation products,
// rounded sums, sqrt3 product, phase mapping).
// Throughput: one transaction per cycle sustained while out_ready stays high.
// Each stage holds its item while the next is full and stalled and fills
// its own bubble otherwise, so a stalled receiver back-pressures the input
// only once every stage is occupied; nothing is dropped or repeated.
// Reset: clears all stage valid bits and sets phase_mode 4 (outputs zero),
// pole_count 1 and use_ext_sincos 0.
module inverse_park_clarke_transform_top #(
  parameter int ANGLE_BITS       = ipc_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = ipc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ipc_pkg::FIELD_W-1:0] in_d_axis,
  input  logic signed [ipc_pkg::FIELD_W-1:0] in_q_axis,
  input  logic [ipc_pkg::FIELD_W-1:0]        in_rotor_angle,
  input  logic signed [ipc_pkg::FIELD_W-1:0] in_ext_sine,
  input  logic signed [ipc_pkg::FIELD_W-1:0] in_ext_cosine,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ipc_pkg::OUT_W-1:0]   out_alpha,
  output logic signed [ipc_pkg::OUT_W-1:0]   out_beta,
  output logic signed [ipc_pkg::OUT_W-1:0]   out_phase_u,
  output logic signed [ipc_pkg::OUT_W-1:0]   out_phase_v,
  output logic signed [ipc_pkg::OUT_W-1:0]   out_phase_w,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int NSTG  = 8;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  ipc_pkg::cfg_t cfg_r, cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_idx;

  logic [NSTG:1]   vld_r, vld_nxt;
  logic [NSTG+1:1] adv;

  ipc_pkg::pair_en_t en_ang, en_sc, en_rot, en_ph;

  logic [1:0]                         a_quad;
  logic [IDX_W-1:0]                   a_idx;
  logic signed [ipc_pkg::FIELD_W-1:0] a_d, a_q, a_es, a_ec;
  logic signed [ipc_pkg::FIELD_W-1:0] s_sin, s_cos, s_d, s_q;
  logic signed [ipc_pkg::OUT_W-1:0]   r_alpha, r_beta;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        ipc_pkg::REG_PHASE_MODE:     cfg_nxt.phase_mode     = pwdata[2:0];
        ipc_pkg::REG_POLE_COUNT:     cfg_nxt.pole_count     = pwdata[7:0];
        ipc_pkg::REG_USE_EXT_SINCOS: cfg_nxt.use_ext_sincos = pwdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
    case (reg_idx)
      ipc_pkg::REG_PHASE_MODE:     prdata = {29'd0, cfg_r.phase_mode};
      ipc_pkg::REG_POLE_COUNT:     prdata = {24'd0, cfg_r.pole_count};
      ipc_pkg::REG_USE_EXT_SINCOS: prdata = {31'd0, cfg_r.use_ext_sincos};
      default:                     prdata = 32'd0;
    endcase
  end

  always_comb begin
    adv[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
    vld_nxt = vld_r;
    for (int k = NSTG; k >= 2; k--) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
    if (adv[1]) begin
      vld_nxt[1] = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_mode     <= ipc_pkg::PM_OFF;
      cfg_r.pole_count     <= 8'd1;
      cfg_r.use_ext_sincos <= 1'b0;
      vld_r                <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[NSTG];

  assign en_ang = '{en_a: adv[1], en_b: adv[2]};
  assign en_sc  = '{en_a: adv[3], en_b: adv[4]};
  assign en_rot = '{en_a: adv[5], en_b: adv[6]};
  assign en_ph  = '{en_a: adv[7], en_b: adv[8]};

  ipc_angle #(
    .ANGLE_BITS       (ANGLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_angle (
    .clk         (clk),
    .en          (en_ang),
    .pole_count  (cfg_r.pole_count),
    .rotor_angle (in_rotor_angle),
    .d_axis      (in_d_axis),
    .q_axis      (in_q_axis),
    .ext_sine    (in_ext_sine),
    .ext_cosine  (in_ext_cosine),
    .quad        (a_quad),
    .idx         (a_idx),
    .d_out       (a_d),
    .q_out       (a_q),
    .es_out      (a_es),
    .ec_out      (a_ec)
  );

  ipc_sincos #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sincos (
    .clk            (clk),
    .en             (en_sc),
    .use_ext_sincos (cfg_r.use_ext_sincos),
    .quad           (a_quad),
    .idx            (a_idx),
    .d_axis         (a_d),
    .q_axis         (a_q),
    .ext_sine       (a_es),
    .ext_cosine     (a_ec),
    .sine           (s_sin),
    .cosine         (s_cos),
    .d_out          (s_d),
    .q_out          (s_q)
  );

  ipc_rotate u_rotate (
    .clk    (clk),
    .en     (en_rot),
    .d_axis (s_d),
    .q_axis (s_q),
    .sine   (s_sin),
    .cosine (s_cos),
    .alpha  (r_alpha),
    .beta   (r_beta)
  );

  ipc_phase u_phase (
    .clk        (clk),
    .en         (en_ph),
    .phase_mode (cfg_r.phase_mode),
    .alpha      (r_alpha),
    .beta       (r_beta),
    .alpha_out  (out_alpha),
    .beta_out   (out_beta),
    .phase_u    (out_phase_u),
    .phase_v    (out_phase_v),
    .phase_w    (out_phase_w)
  );

endmodule
